### src/price_level_order_book_core_assert.svh
`ifndef PRICE_LEVEL_ORDER_BOOK_CORE_ASSERT_SVH
`define PRICE_LEVEL_ORDER_BOOK_CORE_ASSERT_SVH

// same-cycle implication
`define PLOB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define PLOB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/plob_pkg.sv
package plob_pkg;

    localparam logic [1:0] REQ_ADD = 2'd0;
    localparam logic [1:0] REQ_MOD = 2'd1;
    localparam logic [1:0] REQ_DEL = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_DUP     = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic        used;
        logic [31:0] key;
        logic        side;
        logic [31:0] price;
        logic [31:0] volume;
    } t_order;

    typedef struct packed {
        logic        [31:0] price;
        logic signed [39:0] volume;
    } t_level;

    typedef struct packed {
        logic clear;
        logic accept;
        logic oscan;
        logic lscan;
        logic write;
        logic bscan;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic scan_done;
        logic out_free;
    } t_sts;

    // saturating add into the 40-bit signed level range
    function automatic logic signed [39:0] f_sat(input logic signed [39:0] lv,
                                                 input logic signed [33:0] d);
        logic signed [41:0] s;
        logic signed [39:0] r;
        s = $signed({{2{lv[39]}}, lv}) + $signed({{8{d[33]}}, d});
        if (s[41:39] == 3'b000 || s[41:39] == 3'b111) begin
            r = s[39:0];
        end else if (s[41]) begin
            r = {1'b1, 39'd0};
        end else begin
            r = {1'b0, {39{1'b1}}};
        end
        return r;
    endfunction

endpackage

### src/price_level_order_book_core.sv
// each request runs an order table scan and two level table scans through single-port rams;
// no new request is taken until the previous result has been loaded into the output register
// reset clears the level used bits, then a pass over every order table entry clears the order
// table; no input transfer is taken until it ends
module price_level_order_book_core #(
    parameter int MAX_ORDERS = 1024,
    parameter int MAX_LEVELS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_order_id,
    input  logic        i_side,
    input  logic [31:0] i_price,
    input  logic [31:0] i_volume,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_high_bid,
    output logic [31:0] o_low_ask
);

    plob_pkg::t_cmd cmd;
    plob_pkg::t_sts sts;

    plob_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    plob_dp #(
        .MAX_ORDERS (MAX_ORDERS),
        .MAX_LEVELS (MAX_LEVELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req_type  (i_req_type),
        .i_order_id  (i_order_id),
        .i_side      (i_side),
        .i_price     (i_price),
        .i_volume    (i_volume),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_status    (o_status),
        .o_high_bid  (o_high_bid),
        .o_low_ask   (o_low_ask)
    );

endmodule

### src/plob_ram.sv
module plob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/plob_ctrl.sv
`include "price_level_order_book_core_assert.svh"

module plob_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  plob_pkg::t_sts i_sts,
    output plob_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_OSCAN = 7'b0000100,
        S_LSCAN = 7'b0001000,
        S_WRITE = 7'b0010000,
        S_BSCAN = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_OSCAN;
                end
            end
            S_OSCAN: begin
                o_cmd.oscan = 1'b1;
                if (i_sts.scan_done) n_state = S_LSCAN;
            end
            S_LSCAN: begin
                o_cmd.lscan = 1'b1;
                if (i_sts.scan_done) n_state = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = S_BSCAN;
            end
            S_BSCAN: begin
                o_cmd.bscan = 1'b1;
                if (i_sts.scan_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    `PLOB_ASSERT_NEXT(a_accept_scan, i_clk, i_rst_n, r_state == S_IDLE && i_in_valid, r_state == S_OSCAN)
    `PLOB_ASSERT_NOW(a_load_free, i_clk, i_rst_n, o_cmd.load_out, i_sts.out_free)
    `PLOB_ASSERT_NEXT(a_lscan_write, i_clk, i_rst_n, r_state == S_LSCAN && i_sts.scan_done, r_state == S_WRITE)

endmodule

### src/plob_dp.sv
module plob_dp #(
    parameter int MAX_ORDERS = 1024,
    parameter int MAX_LEVELS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  plob_pkg::t_cmd i_cmd,
    output plob_pkg::t_sts o_sts,
    input  logic [1:0]     i_req_type,
    input  logic [31:0]    i_order_id,
    input  logic           i_side,
    input  logic [31:0]    i_price,
    input  logic [31:0]    i_volume,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output logic [1:0]     o_status,
    output logic [31:0]    o_high_bid,
    output logic [31:0]    o_low_ask
);

    localparam int OAW  = $clog2(MAX_ORDERS);
    localparam int LAW  = $clog2(MAX_LEVELS);
    localparam int MAXD = (MAX_ORDERS > MAX_LEVELS) ? MAX_ORDERS : MAX_LEVELS;
    localparam int CW   = $clog2(MAXD) + 1;
    localparam logic [CW-1:0] OLAST = CW'(MAX_ORDERS - 1);
    localparam logic [CW-1:0] LLAST = CW'(MAX_LEVELS - 1);
    localparam int OW   = $bits(plob_pkg::t_order);
    localparam int LW   = $bits(plob_pkg::t_level);

    // scan counter
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_didx;
    logic          r_dv;
    logic          scanning;
    logic [CW-1:0] last;
    logic          issue;
    logic          scan_done;
    logic          clear_done;

    assign scanning   = i_cmd.oscan | i_cmd.lscan | i_cmd.bscan;
    assign last       = i_cmd.oscan ? OLAST : LLAST;
    assign issue      = scanning && (r_cnt <= last);
    assign scan_done  = scanning && r_dv && (r_didx == last);
    assign clear_done = i_cmd.clear && (r_cnt == OLAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_dv  <= 1'b0;
        end else if (i_cmd.clear) begin
            r_cnt <= clear_done ? '0 : r_cnt + 1'b1;
            r_dv  <= 1'b0;
        end else if (scan_done || !scanning) begin
            r_cnt <= '0;
            r_dv  <= 1'b0;
        end else begin
            r_dv <= issue;
            if (issue) r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_didx <= r_cnt;
    end

    // request and search results
    logic [1:0]         r_type;
    logic [31:0]        r_id;
    logic               r_side;
    logic [31:0]        r_price;
    logic [31:0]        r_vol;
    logic               r_ofound;
    logic [OAW-1:0]     r_oidx;
    logic               r_oside;
    logic [31:0]        r_oprice;
    logic [31:0]        r_ovol;
    logic               r_ofree;
    logic [OAW-1:0]     r_ofree_idx;
    logic               r_lfound;
    logic [LAW-1:0]     r_lidx;
    logic signed [39:0] r_lvol;
    logic               r_lfree;
    logic [LAW-1:0]     r_lfree_idx;
    logic               r_bany;
    logic [31:0]        r_bbest;
    logic               r_aany;
    logic [31:0]        r_abest;
    logic [1:0]         r_st;
    logic [MAX_LEVELS-1:0] r_bid_used;
    logic [MAX_LEVELS-1:0] r_ask_used;

    // memories
    logic [OW-1:0]  ord_rdata;
    logic [LW-1:0]  bid_rdata;
    logic [LW-1:0]  ask_rdata;
    logic           ord_we;
    logic [OAW-1:0] ord_addr;
    logic [OW-1:0]  ord_wdata;
    logic           bid_we;
    logic           ask_we;
    logic [LAW-1:0] lvl_addr;
    logic [LW-1:0]  lvl_wdata;

    plob_pkg::t_order ord_rd;
    plob_pkg::t_level bid_rd;
    plob_pkg::t_level ask_rd;
    plob_pkg::t_level lvl_rd;
    logic             lvl_used_rd;
    logic             lscan_side;
    logic [31:0]      lscan_price;

    assign ord_rd      = plob_pkg::t_order'(ord_rdata);
    assign bid_rd      = plob_pkg::t_level'(bid_rdata);
    assign ask_rd      = plob_pkg::t_level'(ask_rdata);
    assign lscan_side  = (r_type == plob_pkg::REQ_ADD) ? r_side : r_oside;
    assign lscan_price = (r_type == plob_pkg::REQ_ADD) ? r_price : r_oprice;
    assign lvl_rd      = lscan_side ? ask_rd : bid_rd;
    assign lvl_used_rd = lscan_side ? r_ask_used[r_didx[LAW-1:0]]
                                    : r_bid_used[r_didx[LAW-1:0]];

    // update decision
    logic               w_ord_we;
    plob_pkg::t_order   w_ord;
    logic [OAW-1:0]     w_oaddr;
    logic               w_lvl_we;
    logic               w_lvl_side;
    logic [LAW-1:0]     w_laddr;
    plob_pkg::t_level   w_lvl;
    logic               w_lvl_keep;
    logic [1:0]         w_st;
    logic signed [33:0] delta;
    logic signed [39:0] nvol;
    logic               full;

    always_comb begin
        w_ord_we   = 1'b0;
        w_ord      = '0;
        w_oaddr    = r_oidx;
        w_lvl_we   = 1'b0;
        w_lvl_side = lscan_side;
        w_laddr    = r_lidx;
        w_lvl_keep = 1'b1;
        w_st       = plob_pkg::ST_DONE;
        delta      = '0;
        full       = (!r_ofound && !r_ofree) || (!r_lfound && !r_lfree);
        unique case (r_type)
            plob_pkg::REQ_ADD: delta = $signed({2'b00, r_vol});
            plob_pkg::REQ_MOD: delta = $signed({2'b00, r_vol}) - $signed({2'b00, r_ovol});
            plob_pkg::REQ_DEL: delta = -$signed({2'b00, r_ovol});
            default:           delta = '0;
        endcase
        nvol        = plob_pkg::f_sat(r_lvol, delta);
        w_lvl.price = lscan_price;
        w_lvl.volume = nvol;
        unique case (r_type)
            plob_pkg::REQ_ADD: begin
                if (full) begin
                    w_st = plob_pkg::ST_FULL;
                end else begin
                    w_lvl_we = 1'b1;
                    if (!r_lfound) begin
                        w_laddr      = r_lfree_idx;
                        w_lvl.volume = $signed({8'd0, r_vol});
                    end
                    if (r_ofound) begin
                        w_st = plob_pkg::ST_DUP;
                    end else begin
                        w_ord_we = 1'b1;
                        w_oaddr  = r_ofree_idx;
                        w_ord    = '{used: 1'b1, key: r_id, side: r_side,
                                     price: r_price, volume: r_vol};
                    end
                end
            end
            plob_pkg::REQ_MOD: begin
                if (!r_ofound) begin
                    w_st = plob_pkg::ST_UNKNOWN;
                end else begin
                    w_lvl_we = r_lfound;
                    w_ord_we = 1'b1;
                    w_ord    = '{used: 1'b1, key: r_id, side: r_oside,
                                 price: r_oprice, volume: r_vol};
                end
            end
            plob_pkg::REQ_DEL: begin
                if (!r_ofound) begin
                    w_st = plob_pkg::ST_UNKNOWN;
                end else begin
                    w_lvl_we   = r_lfound;
                    w_lvl_keep = !(nvol[39] || nvol == 40'sd0);
                    w_ord_we   = 1'b1;
                    w_ord      = '0;
                end
            end
            default: w_st = plob_pkg::ST_DONE;
        endcase
    end

    assign ord_we    = i_cmd.clear || (i_cmd.write && w_ord_we);
    assign ord_addr  = i_cmd.write ? w_oaddr : r_cnt[OAW-1:0];
    assign ord_wdata = i_cmd.clear ? '0 : OW'(w_ord);
    assign bid_we    = i_cmd.write && w_lvl_we && !w_lvl_side;
    assign ask_we    = i_cmd.write && w_lvl_we && w_lvl_side;
    assign lvl_addr  = i_cmd.write ? w_laddr : r_cnt[LAW-1:0];
    assign lvl_wdata = LW'(w_lvl);

    plob_ram #(.WIDTH(OW), .DEPTH(MAX_ORDERS)) u_ord_ram (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_addr  (ord_addr),
        .i_wdata (ord_wdata),
        .o_rdata (ord_rdata)
    );

    plob_ram #(.WIDTH(LW), .DEPTH(MAX_LEVELS)) u_bid_ram (
        .i_clk   (i_clk),
        .i_we    (bid_we),
        .i_addr  (lvl_addr),
        .i_wdata (lvl_wdata),
        .o_rdata (bid_rdata)
    );

    plob_ram #(.WIDTH(LW), .DEPTH(MAX_LEVELS)) u_ask_ram (
        .i_clk   (i_clk),
        .i_we    (ask_we),
        .i_addr  (lvl_addr),
        .i_wdata (lvl_wdata),
        .o_rdata (ask_rdata)
    );

    // level used bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bid_used <= '0;
            r_ask_used <= '0;
        end else if (i_cmd.write && w_lvl_we) begin
            if (w_lvl_side) begin
                r_ask_used[w_laddr] <= w_lvl_keep;
            end else begin
                r_bid_used[w_laddr] <= w_lvl_keep;
            end
        end
    end

    // request capture and search
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ofound <= 1'b0;
            r_ofree  <= 1'b0;
            r_lfound <= 1'b0;
            r_lfree  <= 1'b0;
            r_bany   <= 1'b0;
            r_aany   <= 1'b0;
            r_bbest  <= '0;
            r_abest  <= '0;
        end else if (i_cmd.accept) begin
            r_type   <= i_req_type;
            r_id     <= i_order_id;
            r_side   <= i_side;
            r_price  <= i_price;
            r_vol    <= i_volume;
            r_ofound <= 1'b0;
            r_ofree  <= 1'b0;
            r_lfound <= 1'b0;
            r_lfree  <= 1'b0;
            r_bany   <= 1'b0;
            r_aany   <= 1'b0;
            r_bbest  <= '0;
            r_abest  <= '0;
        end else if (r_dv) begin
            if (i_cmd.oscan) begin
                if (ord_rd.used && ord_rd.key == r_id && !r_ofound) begin
                    r_ofound <= 1'b1;
                    r_oidx   <= r_didx[OAW-1:0];
                    r_oside  <= ord_rd.side;
                    r_oprice <= ord_rd.price;
                    r_ovol   <= ord_rd.volume;
                end
                if (!ord_rd.used && !r_ofree) begin
                    r_ofree     <= 1'b1;
                    r_ofree_idx <= r_didx[OAW-1:0];
                end
            end
            if (i_cmd.lscan) begin
                if (lvl_used_rd && lvl_rd.price == lscan_price && !r_lfound) begin
                    r_lfound <= 1'b1;
                    r_lidx   <= r_didx[LAW-1:0];
                    r_lvol   <= lvl_rd.volume;
                end
                if (!lvl_used_rd && !r_lfree) begin
                    r_lfree     <= 1'b1;
                    r_lfree_idx <= r_didx[LAW-1:0];
                end
            end
            if (i_cmd.bscan) begin
                if (r_bid_used[r_didx[LAW-1:0]] && (!r_bany || bid_rd.price > r_bbest)) begin
                    r_bany  <= 1'b1;
                    r_bbest <= bid_rd.price;
                end
                if (r_ask_used[r_didx[LAW-1:0]] && (!r_aany || ask_rd.price < r_abest)) begin
                    r_aany  <= 1'b1;
                    r_abest <= ask_rd.price;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_st <= w_st;
        end
    end

    // output register
    logic        r_out_valid;
    logic [1:0]  r_status;
    logic [31:0] r_high_bid;
    logic [31:0] r_low_ask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_status   <= r_st;
            r_high_bid <= r_bbest;
            r_low_ask  <= r_abest;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_high_bid       = r_high_bid;
    assign o_low_ask        = r_low_ask;
    assign o_sts.clear_done = clear_done;
    assign o_sts.scan_done  = scan_done;
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

endmodule

### sim/tb_price_level_order_book_core.sv
`timescale 1ns / 1ps

module tb_price_level_order_book_core;

    localparam int NUM_ORDERS = 1024;
    localparam int NUM_LEVELS = 64;
    localparam int BOOK_LATENCY = NUM_ORDERS + 2 * NUM_LEVELS + 6;
    localparam int HOLD_AFTER = 327;
    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam longint LEVEL_MAX = 64'sd549755813887;
    localparam longint LEVEL_MIN = -LEVEL_MAX - 1;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] high_bid;
        logic [31:0] low_ask;
    } t_book_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_req_type;
    logic [31:0] i_order_id;
    logic        i_side;
    logic [31:0] i_price;
    logic [31:0] i_volume;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_high_bid;
    logic [31:0] o_low_ask;

    // book mirror
    bit          ord_used [NUM_ORDERS];
    logic [31:0] ord_key [NUM_ORDERS];
    logic        ord_side [NUM_ORDERS];
    logic [31:0] ord_price [NUM_ORDERS];
    logic [31:0] ord_volume [NUM_ORDERS];
    bit          lvl_used [2][NUM_LEVELS];
    logic [31:0] lvl_price [2][NUM_LEVELS];
    longint      lvl_volume [2][NUM_LEVELS];

    t_book_result expected_books[$];
    logic [31:0]  id_pool [48];
    logic [31:0]  price_pool [24];

    int  mismatches;
    int  results_seen;
    int  requests_sent;
    int  status_seen [4];
    bit  tx_quiet;
    bit  hold_done;
    int  hold_count;
    int  stall_left;

    price_level_order_book_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_req_type (i_req_type),
        .i_order_id (i_order_id),
        .i_side     (i_side),
        .i_price    (i_price),
        .i_volume   (i_volume),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_status   (o_status),
        .o_high_bid (o_high_bid),
        .o_low_ask  (o_low_ask)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic longint clamp_level(input longint v);
        if (v > LEVEL_MAX) begin
            return LEVEL_MAX;
        end
        if (v < LEVEL_MIN) begin
            return LEVEL_MIN;
        end
        return v;
    endfunction

    function automatic int find_order(input logic [31:0] id);
        for (int i = 0; i < NUM_ORDERS; i++) begin
            if (ord_used[i] && ord_key[i] == id) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic int find_level(input int s, input logic [31:0] p);
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (lvl_used[s][i] && lvl_price[s][i] == p) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic int orders_live();
        int n;
        n = 0;
        for (int i = 0; i < NUM_ORDERS; i++) begin
            n += ord_used[i];
        end
        return n;
    endfunction

    function automatic logic [31:0] best_price(input int s);
        bit          any;
        logic [31:0] best;
        any = 0;
        best = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (lvl_used[s][i]) begin
                if (!any || (s == 0 ? lvl_price[s][i] > best : lvl_price[s][i] < best)) begin
                    best = lvl_price[s][i];
                end
                any = 1;
            end
        end
        return best;
    endfunction

    function automatic logic [1:0] apply_add(input logic [31:0] id, input logic s,
                                             input logic [31:0] p, input logic [31:0] v);
        int oi;
        int li;
        int slot;
        oi = find_order(id);
        li = find_level(s, p);
        slot = -1;
        if (oi < 0) begin
            for (int i = 0; i < NUM_ORDERS && slot < 0; i++) begin
                if (!ord_used[i]) begin
                    slot = i;
                end
            end
            if (slot < 0) begin
                return plob_pkg::ST_FULL;
            end
        end
        if (li < 0) begin
            for (int i = 0; i < NUM_LEVELS && li < 0; i++) begin
                if (!lvl_used[s][i]) begin
                    li = i;
                end
            end
            if (li < 0) begin
                return plob_pkg::ST_FULL;
            end
            lvl_used[s][li] = 1;
            lvl_price[s][li] = p;
            lvl_volume[s][li] = longint'(v);
        end else begin
            lvl_volume[s][li] = clamp_level(lvl_volume[s][li] + longint'(v));
        end
        if (oi >= 0) begin
            return plob_pkg::ST_DUP;
        end
        ord_used[slot] = 1;
        ord_key[slot] = id;
        ord_side[slot] = s;
        ord_price[slot] = p;
        ord_volume[slot] = v;
        return plob_pkg::ST_DONE;
    endfunction

    function automatic logic [1:0] apply_change(input logic [31:0] id, input logic [31:0] v,
                                                input bit del);
        int oi;
        int li;
        int s;
        oi = find_order(id);
        if (oi < 0) begin
            return plob_pkg::ST_UNKNOWN;
        end
        s = ord_side[oi];
        li = find_level(s, ord_price[oi]);
        if (del) begin
            if (li >= 0) begin
                lvl_volume[s][li] = clamp_level(lvl_volume[s][li] - longint'(ord_volume[oi]));
                if (lvl_volume[s][li] <= 0) begin
                    lvl_used[s][li] = 0;
                end
            end
            ord_used[oi] = 0;
        end else begin
            if (li >= 0) begin
                lvl_volume[s][li] = clamp_level(lvl_volume[s][li]
                    + (longint'(v) - longint'(ord_volume[oi])));
            end
            ord_volume[oi] = v;
        end
        return plob_pkg::ST_DONE;
    endfunction

    function automatic t_book_result predict_book(input logic [1:0] rt, input logic [31:0] id,
                                                  input logic s, input logic [31:0] p,
                                                  input logic [31:0] v);
        t_book_result r;
        r.status = plob_pkg::ST_DONE;
        case (rt)
            plob_pkg::REQ_ADD: r.status = apply_add(id, s, p, v);
            plob_pkg::REQ_MOD: r.status = apply_change(id, v, 0);
            plob_pkg::REQ_DEL: r.status = apply_change(id, '0, 1);
            default:           r.status = plob_pkg::ST_DONE;
        endcase
        r.high_bid = best_price(0);
        r.low_ask  = best_price(1);
        return r;
    endfunction

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (tx_quiet || r < 45) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(20, 90);
    endfunction

    task automatic send_request(input logic [1:0] rt, input logic [31:0] id, input logic s,
                                input logic [31:0] p, input logic [31:0] v);
        int gap;
        i_in_valid <= 1'b1;
        i_req_type <= rt;
        i_order_id <= id;
        i_side     <= s;
        i_price    <= p;
        i_volume   <= v;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        expected_books.push_back(predict_book(rt, id, s, p, v));
        requests_sent++;
        gap = gap_length();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_books.size() > 0) begin
            @(posedge i_clk);
        end
        @(posedge i_clk);
    endtask

    // result check and receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
            hold_count  <= 0;
            hold_done   <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_books.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected transfer: status %0d bid %h ask %h",
                                 o_status, o_high_bid, o_low_ask);
                    end
                end else begin
                    t_book_result e;
                    e = expected_books.pop_front();
                    status_seen[e.status]++;
                    if (o_status !== e.status || o_high_bid !== e.high_bid ||
                        o_low_ask !== e.low_ask) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result %0d: expected status %0d bid %h ask %h, got %0d %h %h",
                                     results_seen, e.status, e.high_bid, e.low_ask,
                                     o_status, o_high_bid, o_low_ask);
                        end
                    end
                end
            end
            if (!hold_done && hold_count == 0 && requests_sent >= HOLD_AFTER) begin
                hold_count  <= 3000;
                hold_done   <= 1'b1;
                i_out_stall <= 1'b1;
            end else if (hold_count > 1) begin
                hold_count <= hold_count - 1;
            end else if (hold_count == 1) begin
                hold_count  <= 0;
                i_out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_out_stall <= (stall_left > 1);
            end else begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    stall_left  <= $urandom_range(1, 4);
                    i_out_stall <= 1'b1;
                end else if (r < 10) begin
                    stall_left  <= $urandom_range(300, 1500);
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    task automatic test_directed();
        send_request(plob_pkg::REQ_ADD, 32'h0000_0000, 1'b0, 32'h0000_0000, 32'h0000_0005);
        send_request(plob_pkg::REQ_ADD, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(plob_pkg::REQ_ADD, 32'h5555_AAAA, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(plob_pkg::REQ_ADD, 32'hAAAA_5555, 1'b1, 32'h0000_0000, 32'h8000_0000);
        send_request(plob_pkg::REQ_ADD, 32'h5555_AAAA, 1'b1, 32'h0000_0100, 32'h0000_0007);
        send_request(plob_pkg::REQ_MOD, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(plob_pkg::REQ_MOD, 32'h1234_5678, 1'b0, 32'h0, 32'h1);
        send_request(plob_pkg::REQ_DEL, 32'h1234_5678, 1'b1, 32'h0, 32'h0);
        send_request(REQ_NONE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(plob_pkg::REQ_DEL, 32'hAAAA_5555, 1'b0, 32'h0, 32'h0);
        send_request(plob_pkg::REQ_DEL, 32'h0000_0000, 1'b0, 32'h0, 32'h0);
        send_request(plob_pkg::REQ_DEL, 32'h0000_0000, 1'b0, 32'h0, 32'h0);
        // level removed under a live order, then driven negative
        send_request(plob_pkg::REQ_ADD, 32'h0000_0101, 1'b1, 32'hFFFF_FF00, 32'd100);
        send_request(plob_pkg::REQ_ADD, 32'h0000_0102, 1'b1, 32'hFFFF_FF00, 32'd0);
        send_request(plob_pkg::REQ_MOD, 32'h0000_0101, 1'b0, 32'h0, 32'd0);
        send_request(plob_pkg::REQ_DEL, 32'h0000_0102, 1'b0, 32'h0, 32'h0);
        send_request(plob_pkg::REQ_MOD, 32'h0000_0101, 1'b0, 32'h0, 32'hFFFF_FFFF);
        send_request(plob_pkg::REQ_ADD, 32'h0000_0103, 1'b1, 32'hFFFF_FF00, 32'd1);
        send_request(plob_pkg::REQ_MOD, 32'h0000_0101, 1'b0, 32'h0, 32'd0);
        send_request(plob_pkg::REQ_DEL, 32'h0000_0103, 1'b0, 32'h0, 32'h0);
        send_request(plob_pkg::REQ_ADD, 32'h0000_0104, 1'b1, 32'hFFFF_FF00, 32'hFFFF_FFFF);
        send_request(plob_pkg::REQ_DEL, 32'h0000_0101, 1'b0, 32'h0, 32'h0);
        send_request(plob_pkg::REQ_DEL, 32'h0000_0104, 1'b0, 32'h0, 32'h0);
        send_request(plob_pkg::REQ_DEL, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0);
        send_request(plob_pkg::REQ_DEL, 32'h5555_AAAA, 1'b0, 32'h0, 32'h0);
    endtask

    // the order table fill leaves the bid level at price_pool[2] at the upper bound
    task automatic test_level_saturation();
        send_request(plob_pkg::REQ_DEL, 32'hC000_0010, 1'b0, 32'h0, 32'h0);
        send_request(plob_pkg::REQ_ADD, 32'hC000_0011, 1'b0, price_pool[2], 32'hFFFF_FFFF);
        send_request(plob_pkg::REQ_MOD, 32'hC000_0012, 1'b0, 32'h0, 32'h0);
        send_request(plob_pkg::REQ_MOD, 32'hC000_0012, 1'b0, 32'h0, 32'hFFFF_FFFF);
        send_request(plob_pkg::REQ_ADD, 32'h0000_5A7B, 1'b0, 32'd1, 32'h0000_0001);
        send_request(plob_pkg::REQ_MOD, 32'h0000_5A7B, 1'b0, 32'h0, 32'hFFFF_FFFF);
        send_request(plob_pkg::REQ_DEL, 32'h0000_5A7B, 1'b0, 32'h0, 32'h0);
    endtask

    task automatic test_level_table_full();
        for (int s = 0; s < 2; s++) begin
            for (int k = 0; k <= NUM_LEVELS; k++) begin
                send_request(plob_pkg::REQ_ADD, 32'hA000_0000 + s * 256 + k, s[0],
                             32'd5000 + k * 3, $urandom_range(1, 1000));
            end
            send_request(plob_pkg::REQ_ADD, 32'hA000_0000 + s * 256, s[0], 32'd7, 32'd9);
            for (int k = 0; k <= NUM_LEVELS; k++) begin
                send_request(plob_pkg::REQ_DEL, 32'hA000_0000 + s * 256 + k, s[0], 32'h0,
                             32'h0);
            end
        end
    endtask

    function automatic logic [31:0] live_id();
        int start;
        start = $urandom_range(0, NUM_ORDERS - 1);
        for (int i = 0; i < NUM_ORDERS; i++) begin
            if (ord_used[(start + i) % NUM_ORDERS]) begin
                return ord_key[(start + i) % NUM_ORDERS];
            end
        end
        return id_pool[$urandom_range(0, 47)];
    endfunction

    function automatic logic [31:0] random_volume();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            2, 3: return $urandom();
            default: return $urandom_range(1, 5000);
        endcase
    endfunction

    task automatic test_random_traffic();
        int r;
        for (int i = 0; i < 48; i++) begin
            id_pool[i] = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom();
        end
        for (int i = 0; i < 24; i++) begin
            price_pool[i] = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom();
        end
        for (int n = 0; n < 100; n++) begin
            if (n % 60 == 0) begin
                tx_quiet = $urandom_range(0, 1);
            end
            r = $urandom_range(0, 99);
            if (r < 45) begin
                send_request(plob_pkg::REQ_ADD, id_pool[$urandom_range(0, 47)],
                             1'($urandom_range(0, 1)), price_pool[$urandom_range(0, 23)],
                             random_volume());
            end else if (r < 70) begin
                send_request(plob_pkg::REQ_MOD, live_id(), 1'($urandom_range(0, 1)),
                             $urandom(), random_volume());
            end else if (r < 92) begin
                send_request(plob_pkg::REQ_DEL, live_id(), 1'($urandom_range(0, 1)),
                             $urandom(), $urandom());
            end else if (r < 97) begin
                send_request(2'($urandom_range(1, 2)), $urandom(), 1'($urandom_range(0, 1)),
                             $urandom(), $urandom());
            end else begin
                send_request(REQ_NONE, $urandom(), 1'($urandom_range(0, 1)), $urandom(),
                             $urandom());
            end
        end
        tx_quiet = 0;
    endtask

    task automatic test_order_table_full();
        int k;
        k = 0;
        while (orders_live() < NUM_ORDERS) begin
            send_request(plob_pkg::REQ_ADD, 32'hC000_0000 + k, 1'b0, price_pool[2],
                         32'hFFFF_FFFF);
            k++;
        end
        send_request(plob_pkg::REQ_ADD, 32'hD000_0000, 1'b1, price_pool[3], 32'd4);
        send_request(plob_pkg::REQ_ADD, 32'hC000_0000, 1'b0, price_pool[2], 32'd4);
        send_request(plob_pkg::REQ_DEL, 32'hC000_0003, 1'b0, 32'h0, 32'h0);
        send_request(plob_pkg::REQ_ADD, 32'hD000_0000, 1'b1, price_pool[3], 32'd4);
        send_request(plob_pkg::REQ_MOD, 32'hC000_0000, 1'b0, 32'h0, 32'd0);
        send_request(plob_pkg::REQ_DEL, 32'hC000_0001, 1'b0, 32'h0, 32'h0);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_req_type   = plob_pkg::REQ_ADD;
        i_order_id   = '0;
        i_side       = 1'b0;
        i_price      = '0;
        i_volume     = '0;
        tx_quiet     = 1'b0;
        mismatches   = 0;
        results_seen = 0;
        requests_sent = 0;
        status_seen  = '{default: 0};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_level_table_full();
        test_random_traffic();
        test_order_table_full();
        test_level_saturation();
        drain_results();
        repeat (BOOK_LATENCY + 20) @(posedge i_clk);
        $display("%0d requests, %0d results checked; status done/unknown/dup/full: %0d/%0d/%0d/%0d",
                 requests_sent, results_seen, status_seen[0], status_seen[1],
                 status_seen[2], status_seen[3]);
        $display("covered price extremes, both level tables and the order table full, a long output hold and level saturation");
        if (mismatches == 0 && expected_books.size() == 0) begin
            $display("tb_price_level_order_book_core: PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("tb_price_level_order_book_core: FAIL");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("timeout");
        $display("tb_price_level_order_book_core: FAIL");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/plob_pkg.sv
src/plob_ram.sv
src/plob_ctrl.sv
src/plob_dp.sv
src/price_level_order_book_core.sv
sim/tb_price_level_order_book_core.sv
